// File: rtl/sxt_pkg.sv
// Shared types, codes and character constants of the S-expression tokenizer.
package sxt_pkg;

    // Token kinds carried on the output word
    typedef enum logic [2:0] {
        KIND_OPEN  = 3'd0,
        KIND_CLOSE = 3'd1,
        KIND_SYM   = 3'd2,
        KIND_STR   = 3'd3,
        KIND_NUM   = 3'd4,
        KIND_ERR   = 3'd5,
        KIND_DONE  = 3'd6
    } tok_kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_EXP_OPEN = 3'd1,
        ERR_BAD_START = 3'd2,
        ERR_BAD_SYM  = 3'd3,
        ERR_BAD_NUM  = 3'd4,
        ERR_CUT_OFF  = 3'd5
    } err_code_t;

    // Lexer modes
    typedef enum logic [6:0] {
        MODE_WAIT = 7'b0000001,
        MODE_IDLE = 7'b0000010,
        MODE_SYM  = 7'b0000100,
        MODE_NUM  = 7'b0001000,
        MODE_STR  = 7'b0010000,
        MODE_ESC  = 7'b0100000,
        MODE_HALT = 7'b1000000
    } lex_mode_t;

    // Characters of the syntax
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    // Token queue between lexer and serializer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One token word
    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] start;
        logic [15:0] length;
        err_code_t   err;
        logic [7:0]  bad_byte;
    } tok_rec_t;

    // All token words caused by one input byte
    typedef struct packed {
        tok_rec_t [2:0] recs;
        logic [1:0]     cnt;
    } tok_bundle_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic tok_rec_t mk_rec(input tok_kind_t k, input logic [15:0] s,
                                        input logic [15:0] l, input err_code_t e,
                                        input logic [7:0] b);
        tok_rec_t r;
        r.kind     = k;
        r.start    = s;
        r.length   = l;
        r.err      = e;
        r.bad_byte = b;
        return r;
    endfunction

endpackage

// File: rtl/sxt_if.sv
// Handshake channels of the tokenizer: input bytes and output tokens.
interface sxt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_buffer;

    modport source (output valid, in_byte, end_of_buffer, input ready);
    modport sink   (input valid, in_byte, end_of_buffer, output ready);
endinterface

interface sxt_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [2:0]  error_code;
    logic [7:0]  offending_byte;
    logic        last;

    modport source (output valid, token_kind, token_start, token_length, error_code,
                    offending_byte, last, input ready);
    modport sink   (input valid, token_kind, token_start, token_length, error_code,
                    offending_byte, last, output ready);
endinterface

// File: rtl/sxt_front.sv
// Lexer front end: classifies each byte, advances the lexer mode and builds token words.
module sxt_front #(
    parameter int POS_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    sxt_byte_if.sink            text,
    output logic                q_push,
    output sxt_pkg::tok_bundle_t push_data,
    input  sxt_pkg::q_stat_t    q_stat
);
    import sxt_pkg::*;

    lex_mode_t              mode_reg, mode_next, mode_mid;
    logic [POS_WIDTH-1:0]   pos_reg, pos_next;
    logic [POS_WIDTH-1:0]   astart_reg, astart_next, astart_mid;
    logic [POS_WIDTH-1:0]   alen_reg, alen_next, alen_mid;
    logic [POS_WIDTH-1:0]   alen_inc, pos_inc, total;
    logic [7:0]             b;
    logic                   fire;
    logic                   is_ws, is_lower, is_digit, sym_ok, num_ok;
    tok_bundle_t            bundle;
    tok_kind_t              atom_kind;
    logic [1:0]             nrec;

    // Keep the low 16 bits of a position, zero-extending narrow ones
    function automatic logic [15:0] lo16(input logic [POS_WIDTH-1:0] v);
        logic [POS_WIDTH+15:0] w;
        w = {16'b0, v};
        return w[15:0];
    endfunction

    assign b          = text.in_byte;
    assign text.ready = !q_stat.full;
    assign fire       = text.valid && text.ready;

    // Classify the byte
    always_comb
    begin
        is_ws    = b inside {8'h20, [8'h09:8'h0D]};
        is_lower = b inside {[8'h61:8'h7A]};
        is_digit = b inside {[8'h30:8'h39]};
        sym_ok   = is_lower || is_digit || b == CH_DASH || b == CH_UNDER;
        num_ok   = is_digit || b == CH_DOT;
    end

    assign alen_inc  = (alen_reg == '1) ? alen_reg : alen_reg + 1'b1;
    assign pos_inc   = pos_reg + 1'b1;
    assign total     = (pos_reg == '1) ? pos_reg : pos_inc;
    assign atom_kind = (mode_reg == MODE_SYM) ? KIND_SYM : KIND_NUM;

    // Step the lexer and collect the token words of this byte
    always_comb
    begin
        bundle     = '0;
        nrec       = 2'd0;
        mode_mid   = mode_reg;
        astart_mid = astart_reg;
        alen_mid   = alen_reg;
        case (mode_reg)
            MODE_WAIT:
            begin
                if (!is_ws)
                begin
                    if (b == CH_OPEN)
                    begin
                        bundle.recs[0] = mk_rec(KIND_OPEN, lo16(pos_reg), 16'd0, ERR_NONE, 8'd0);
                        mode_mid = MODE_IDLE;
                    end
                    else
                    begin
                        bundle.recs[0] = mk_rec(KIND_ERR, lo16(pos_reg), 16'd0, ERR_EXP_OPEN, b);
                        mode_mid = MODE_HALT;
                    end
                    nrec = 2'd1;
                end
            end
            MODE_IDLE:
            begin
                if (!is_ws)
                begin
                    if (b == CH_OPEN)
                    begin
                        bundle.recs[0] = mk_rec(KIND_OPEN, lo16(pos_reg), 16'd0, ERR_NONE, 8'd0);
                        nrec = 2'd1;
                    end
                    else if (b == CH_CLOSE)
                    begin
                        bundle.recs[0] = mk_rec(KIND_CLOSE, lo16(pos_reg), 16'd0, ERR_NONE, 8'd0);
                        nrec = 2'd1;
                    end
                    else if (is_lower)
                    begin
                        mode_mid   = MODE_SYM;
                        astart_mid = pos_reg;
                        alen_mid   = POS_WIDTH'(1);
                    end
                    else if (b == CH_QUOTE)
                    begin
                        mode_mid   = MODE_STR;
                        astart_mid = pos_inc;
                        alen_mid   = '0;
                    end
                    else if (is_digit || b == CH_DASH)
                    begin
                        mode_mid   = MODE_NUM;
                        astart_mid = pos_reg;
                        alen_mid   = POS_WIDTH'(1);
                    end
                    else
                    begin
                        bundle.recs[0] = mk_rec(KIND_ERR, lo16(pos_reg), 16'd0, ERR_BAD_START, b);
                        nrec     = 2'd1;
                        mode_mid = MODE_HALT;
                    end
                end
            end
            MODE_SYM, MODE_NUM:
            begin
                if (is_ws || b == CH_CLOSE)
                begin
                    bundle.recs[0] = mk_rec(atom_kind, lo16(astart_reg), lo16(alen_reg),
                                            ERR_NONE, 8'd0);
                    nrec     = 2'd1;
                    mode_mid = MODE_IDLE;
                    if (b == CH_CLOSE)
                    begin
                        bundle.recs[1] = mk_rec(KIND_CLOSE, lo16(pos_reg), 16'd0, ERR_NONE, 8'd0);
                        nrec = 2'd2;
                    end
                end
                else if ((mode_reg == MODE_SYM) ? sym_ok : num_ok)
                begin
                    alen_mid = alen_inc;
                end
                else
                begin
                    bundle.recs[0] = mk_rec(KIND_ERR, lo16(pos_reg), 16'd0,
                                            (mode_reg == MODE_SYM) ? ERR_BAD_SYM : ERR_BAD_NUM, b);
                    nrec     = 2'd1;
                    mode_mid = MODE_HALT;
                end
            end
            MODE_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    bundle.recs[0] = mk_rec(KIND_STR, lo16(astart_reg), lo16(alen_reg),
                                            ERR_NONE, 8'd0);
                    nrec     = 2'd1;
                    mode_mid = MODE_IDLE;
                end
                else
                begin
                    alen_mid = alen_inc;
                    if (b == CH_BSLASH)
                    begin
                        mode_mid = MODE_ESC;
                    end
                end
            end
            MODE_ESC:
            begin
                alen_mid = alen_inc;
                mode_mid = MODE_STR;
            end
            default:
            begin
                mode_mid = MODE_HALT;
            end
        endcase

        // Close the buffer on its final byte
        if (text.end_of_buffer)
        begin
            if (mode_mid == MODE_SYM || mode_mid == MODE_NUM ||
                mode_mid == MODE_STR || mode_mid == MODE_ESC)
            begin
                bundle.recs[nrec] = mk_rec(KIND_ERR, lo16(astart_mid), lo16(alen_mid),
                                           ERR_CUT_OFF, 8'd0);
                nrec = nrec + 2'd1;
            end
            else if (mode_mid != MODE_HALT)
            begin
                bundle.recs[nrec] = mk_rec(KIND_DONE, 16'd0, lo16(total), ERR_NONE, 8'd0);
                nrec = nrec + 2'd1;
            end
        end
        bundle.cnt = nrec;
    end

    assign q_push    = fire && (nrec != 2'd0);
    assign push_data = bundle;

    // Advance lexer state; start over after the final byte
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        astart_next = astart_reg;
        alen_next   = alen_reg;
        if (fire)
        begin
            if (text.end_of_buffer)
            begin
                mode_next   = MODE_WAIT;
                pos_next    = '0;
                astart_next = '0;
                alen_next   = '0;
            end
            else
            begin
                mode_next   = mode_mid;
                pos_next    = pos_inc;
                astart_next = astart_mid;
                alen_next   = alen_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_WAIT;
            pos_reg    <= '0;
            astart_reg <= '0;
            alen_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            astart_reg <= astart_next;
            alen_reg   <= alen_next;
        end
    end

endmodule

// File: rtl/sxt_fifo.sv
// Short queue of token groups between the lexer and the output serializer.
module sxt_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sxt_pkg::tok_bundle_t push_data,
    input  logic                 pop,
    output sxt_pkg::tok_bundle_t head,
    output sxt_pkg::q_stat_t     stat
);
    import sxt_pkg::*;

    tok_bundle_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Move pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed group
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/sxt_back.sv
// Serializer: holds one token group and sends one word per cycle unless stalled.
module sxt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sxt_pkg::tok_bundle_t head,
    input  sxt_pkg::q_stat_t     q_stat,
    output logic                 pop,
    sxt_token_if.source          tokens
);
    import sxt_pkg::*;

    tok_bundle_t hold_reg;
    logic        hold_valid_reg, hold_valid_next;
    logic [1:0]  idx_reg, idx_next;
    tok_rec_t    cur;
    logic        is_last, take, load;

    assign cur     = hold_reg.recs[idx_reg];
    assign is_last = (idx_reg == hold_reg.cnt - 2'd1);
    assign take    = hold_valid_reg && tokens.ready;
    assign load    = !q_stat.empty && (!hold_valid_reg || (take && is_last));
    assign pop     = load;

    // Drive the output word from the held group
    assign tokens.valid          = hold_valid_reg;
    assign tokens.token_kind     = cur.kind;
    assign tokens.token_start    = cur.start;
    assign tokens.token_length   = cur.length;
    assign tokens.error_code     = cur.err;
    assign tokens.offending_byte = cur.bad_byte;
    assign tokens.last           = is_last;

    // Advance through the group, load the next one when the last word leaves
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        idx_next        = idx_reg;
        if (load)
        begin
            hold_valid_next = 1'b1;
            idx_next        = 2'd0;
        end
        else if (take && is_last)
        begin
            hold_valid_next = 1'b0;
            idx_next        = 2'd0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= head;
        end
    end

endmodule

// File: rtl/sexpr_tokenizer.sv
// Top level of the streaming S-expression tokenizer.
//
// The block takes one text byte per cycle on the text channel and returns token words
// (open, close, symbol, string, number, error, done) on the tokens channel, with start
// offset and length. The lexer front end accepts a byte every cycle as long as its
// four-entry token queue has room; one byte causes zero to three token words, and the
// output serializer sends one word per cycle unless stalled, so the sustained rate is one
// byte per cycle while bytes yield at most one word each, and the output port sets the pace
// when they yield more. A token passes the token queue and the serializer's hold register
// before it is output. The last flag marks the final word caused by one byte. Positions are
// POS_WIDTH bits wide internally and wrap; lengths saturate; outputs carry the low 16 bits.
module sexpr_tokenizer #(
    parameter int POS_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sxt_byte_if.sink     text,
    sxt_token_if.source  tokens
);
    import sxt_pkg::*;

    logic        q_push;
    logic        q_pop;
    tok_bundle_t push_data;
    tok_bundle_t q_head;
    q_stat_t     q_stat;

    sxt_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .q_push    (q_push),
        .push_data (push_data),
        .q_stat    (q_stat)
    );

    sxt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    sxt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .pop    (q_pop),
        .tokens (tokens)
    );

endmodule

// File: rtl/sxt_checker.sv
// Port-level checks of the tokenizer output, bound to the top level.
module sxt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  token_kind,
    input logic [15:0] token_start,
    input logic [15:0] token_length,
    input logic [2:0]  error_code,
    input logic [7:0]  offending_byte,
    input logic        last
);
    import sxt_pkg::*;

    // A stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
        $stable(token_start) && $stable(token_length) && $stable(error_code) &&
        $stable(offending_byte) && $stable(last))
        else $error("token word changed while stalled");

    // Error and done words close the group of their byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == KIND_ERR || token_kind == KIND_DONE) |-> last)
        else $error("error or done word not marked last");

    // Parentheses carry no length and no error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == KIND_OPEN || token_kind == KIND_CLOSE) |->
        token_length == 16'd0 && error_code == ERR_NONE && offending_byte == 8'd0)
        else $error("parenthesis word with length or error");

    // Only error words carry an error code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((token_kind == KIND_ERR) == (error_code != ERR_NONE)))
        else $error("error code does not match token kind");

endmodule

bind sexpr_tokenizer sxt_checker u_sxt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (tokens.valid),
    .out_ready      (tokens.ready),
    .token_kind     (tokens.token_kind),
    .token_start    (tokens.token_start),
    .token_length   (tokens.token_length),
    .error_code     (tokens.error_code),
    .offending_byte (tokens.offending_byte),
    .last           (tokens.last)
);

// File: tb/sexpr_tokenizer_tb.sv
// Self-checking testbench of the S-expression tokenizer: byte stimulus, token prediction.
module sexpr_tokenizer_tb;
    import sxt_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 16;

    // One expected token word and its last flag
    typedef struct {
        tok_rec_t rec;
        logic     last;
    } tok_word_t;

    // Tracks the lexer state and holds the token words still owed by the block
    class token_scoreboard;
        lex_mode_t   mode;
        logic [15:0] pos;
        logic [15:0] atom_start;
        logic [15:0] atom_len;
        tok_word_t   owed_q[$];
        tok_rec_t    fresh[$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            mode       = MODE_WAIT;
            pos        = '0;
            atom_start = '0;
            atom_len   = '0;
        endfunction

        function bit is_space(logic [7:0] b);
            return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
        endfunction

        function bit is_lower(logic [7:0] b);
            return b >= 8'h61 && b <= 8'h7A;
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= 8'h30 && b <= 8'h39;
        endfunction

        function void put(tok_kind_t k, logic [15:0] s, logic [15:0] l, err_code_t e,
                          logic [7:0] bb);
            tok_rec_t r;
            r.kind     = k;
            r.start    = s;
            r.length   = l;
            r.err      = e;
            r.bad_byte = bb;
            fresh.push_back(r);
        endfunction

        // Saturate the running atom length
        function void grow();
            if (atom_len != 16'hFFFF)
                atom_len++;
        endfunction

        function void halt_on(err_code_t e, logic [7:0] b);
            put(KIND_ERR, pos, 16'd0, e, b);
            mode = MODE_HALT;
        endfunction

        // Advance a bare symbol or number by one byte
        function void atom_byte(logic [7:0] b, tok_kind_t k);
            bit ok;
            if (is_space(b) || b == CH_CLOSE)
            begin
                put(k, atom_start, atom_len, ERR_NONE, 8'd0);
                mode = MODE_IDLE;
                if (b == CH_CLOSE)
                    put(KIND_CLOSE, pos, 16'd0, ERR_NONE, 8'd0);
                return;
            end
            if (k == KIND_SYM)
                ok = is_lower(b) || is_digit(b) || b == CH_DASH || b == CH_UNDER;
            else
                ok = is_digit(b) || b == CH_DOT;
            if (ok)
                grow();
            else
                halt_on((k == KIND_SYM) ? ERR_BAD_SYM : ERR_BAD_NUM, b);
        endfunction

        // Predict the words caused by one accepted byte and queue them
        function void note_byte(logic [7:0] b, logic eob);
            tok_word_t w;
            fresh.delete();
            case (mode)
                MODE_WAIT:
                begin
                    if (!is_space(b))
                    begin
                        if (b == CH_OPEN)
                        begin
                            put(KIND_OPEN, pos, 16'd0, ERR_NONE, 8'd0);
                            mode = MODE_IDLE;
                        end
                        else
                            halt_on(ERR_EXP_OPEN, b);
                    end
                end
                MODE_IDLE:
                begin
                    if (is_space(b))
                        ;
                    else if (b == CH_OPEN)
                        put(KIND_OPEN, pos, 16'd0, ERR_NONE, 8'd0);
                    else if (b == CH_CLOSE)
                        put(KIND_CLOSE, pos, 16'd0, ERR_NONE, 8'd0);
                    else if (is_lower(b))
                    begin
                        mode       = MODE_SYM;
                        atom_start = pos;
                        atom_len   = 16'd1;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        mode       = MODE_STR;
                        atom_start = pos + 16'd1;
                        atom_len   = 16'd0;
                    end
                    else if (is_digit(b) || b == CH_DASH)
                    begin
                        mode       = MODE_NUM;
                        atom_start = pos;
                        atom_len   = 16'd1;
                    end
                    else
                        halt_on(ERR_BAD_START, b);
                end
                MODE_SYM:
                    atom_byte(b, KIND_SYM);
                MODE_NUM:
                    atom_byte(b, KIND_NUM);
                MODE_STR:
                begin
                    if (b == CH_QUOTE)
                    begin
                        put(KIND_STR, atom_start, atom_len, ERR_NONE, 8'd0);
                        mode = MODE_IDLE;
                    end
                    else
                    begin
                        grow();
                        if (b == CH_BSLASH)
                            mode = MODE_ESC;
                    end
                end
                MODE_ESC:
                begin
                    grow();
                    mode = MODE_STR;
                end
                default:
                    mode = MODE_HALT;
            endcase

            // Close the buffer: cut-off atom, done, or silence after an error
            if (eob)
            begin
                if (mode == MODE_SYM || mode == MODE_NUM || mode == MODE_STR ||
                    mode == MODE_ESC)
                    put(KIND_ERR, atom_start, atom_len, ERR_CUT_OFF, 8'd0);
                else if (mode != MODE_HALT)
                    put(KIND_DONE, 16'd0, (pos == 16'hFFFF) ? pos : pos + 16'd1,
                        ERR_NONE, 8'd0);
                restart();
            end
            else
                pos = pos + 16'd1;

            foreach (fresh[i])
            begin
                w.rec  = fresh[i];
                w.last = (i == fresh.size() - 1);
                owed_q.push_back(w);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
                report($sformatf("%s expected %0h got %0h", name, want, got));
        endtask

        // Compare one accepted word with the oldest owed word
        task check_token(logic [2:0] kind, logic [15:0] start, logic [15:0] length,
                         logic [2:0] err, logic [7:0] bad, logic last);
            tok_word_t w;
            if (owed_q.size() == 0)
            begin
                report($sformatf("unexpected word kind %0d start %0h", kind, start));
                return;
            end
            w = owed_q.pop_front();
            check_field("token_kind", 16'(w.rec.kind), 16'(kind));
            check_field("token_start", w.rec.start, start);
            check_field("token_length", w.rec.length, length);
            check_field("error_code", 16'(w.rec.err), 16'(err));
            check_field("offending_byte", 16'(w.rec.bad_byte), 16'(bad));
            check_field("last", 16'(w.last), 16'(last));
        endtask
    endclass

    logic clk;
    logic rst_n;

    sxt_byte_if  text_ch ();
    sxt_token_if token_ch ();

    sexpr_tokenizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (token_ch)
    );

    token_scoreboard sb;
    int src_max;
    int snk_max;
    int sent;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Pick one character of a set
    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] ws_byte();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? 8'h20 : 8'(r);
    endfunction

    // Append a symbol, number or string; an open string is left unterminated
    function automatic void add_atom(ref logic [7:0] q[$], input int k, input bit closed);
        logic [7:0] c;
        case (k)
            0:
            begin
                q.push_back(pick("abcdefghijklmnopqrstuvwxyz"));
                repeat ($urandom_range(0, 4))
                    q.push_back(pick("abcdefghijklmnopqrstuvwxyz0123456789-_"));
            end
            1:
            begin
                q.push_back(pick("0123456789-"));
                repeat ($urandom_range(0, 4))
                    q.push_back(pick("0123456789."));
            end
            default:
            begin
                q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 4))
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        q.push_back(CH_BSLASH);
                        q.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        c = 8'($urandom_range(0, 255));
                        if (c == CH_QUOTE || c == CH_BSLASH)
                            c = 8'h41;
                        q.push_back(c);
                    end
                end
                if (closed)
                    q.push_back(CH_QUOTE);
                else if ($urandom_range(0, 1) == 1)
                    q.push_back(CH_BSLASH);
            end
        endcase
    endfunction

    // Build one buffer: mostly well-formed lists, some broken, some pure noise
    function automatic void make_buffer(ref logic [7:0] q[$]);
        int sel;
        q.delete();
        if ($urandom_range(0, 99) < 15)
        begin
            if ($urandom_range(0, 1) == 1)
                q.push_back(CH_OPEN);
            repeat ($urandom_range(1, 8))
                q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2))
            q.push_back(ws_byte());
        q.push_back(CH_OPEN);
        repeat ($urandom_range(1, 6))
        begin
            sel = $urandom_range(0, 5);
            if (sel <= 2)
            begin
                add_atom(q, sel, 1'b1);
                if (sel != 2 && $urandom_range(0, 3) == 0)
                    q.push_back(CH_CLOSE);
            end
            else if (sel == 3)
                q.push_back(CH_OPEN);
            else
                q.push_back(CH_CLOSE);
            q.push_back(ws_byte());
        end
        if ($urandom_range(0, 9) < 2)
            add_atom(q, $urandom_range(0, 2), 1'b0);
        else
            q.push_back(CH_CLOSE);
        if ($urandom_range(0, 99) < 15)
            q[$urandom_range(1, q.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // Drive one byte word and hold it until the block takes it
    task automatic send_byte(logic [7:0] b, logic eob);
        int gap;
        gap = $urandom_range(0, src_max);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid         <= 1'b1;
        text_ch.in_byte       <= b;
        text_ch.end_of_buffer <= eob;
        do
            @(posedge clk);
        while (!text_ch.ready);
        sb.note_byte(b, eob);
        sent++;
    endtask

    task automatic send_buffer(ref logic [7:0] q[$]);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Hold off the sender until every owed word has arrived
    task automatic drain();
        text_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic random_phase(int upto);
        logic [7:0] q[$];
        while (sent < upto)
        begin
            make_buffer(q);
            send_buffer(q);
        end
    endtask

    // Token sink: stall at random, check every accepted word
    initial
    begin : token_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, snk_max);
            if (stall > 0)
            begin
                token_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            token_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!token_ch.valid);
            sb.check_token(token_ch.token_kind, token_ch.token_start, token_ch.token_length,
                           token_ch.error_code, token_ch.offending_byte, token_ch.last);
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        sb      = new();
        src_max = 3;
        snk_max = 3;
        sent    = 0;
        rst_n                 <= 1'b0;
        text_ch.valid         <= 1'b0;
        text_ch.in_byte       <= 8'd0;
        text_ch.end_of_buffer <= 1'b0;
        token_ch.ready        <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: leading whitespace, every token kind, each error and cut-off
        send_text("\t(a_-9)");
        send_text("x");
        send_text("(\"\\\"\"");
        send_text("(-1.5 7");
        send_text("(a#");
        send_text("(1a");
        send_byte(CH_OPEN, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("(\"\\");
        send_text(" ");
        send_text("())");

        // Random buffers under different idling mixes
        src_max = 18;
        snk_max = 18;
        random_phase(150);
        drain();
        src_max = 0;
        snk_max = 0;
        random_phase(240);
        src_max = 0;
        snk_max = 18;
        random_phase(320);
        src_max = 18;
        snk_max = 0;
        random_phase(400);
        drain();
        src_max = 18;
        snk_max = 18;
        random_phase(450);

        // Wait out owed words and any stray late ones
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sxt_pkg.sv
rtl/sxt_if.sv
rtl/sxt_front.sv
rtl/sxt_fifo.sv
rtl/sxt_back.sv
rtl/sexpr_tokenizer.sv
rtl/sxt_checker.sv
tb/sexpr_tokenizer_tb.sv
